/* sv/window_convolution_3x3_macros.svh */
// Assertion macros shared by the 3x3 window convolution RTL.
// Depends on nothing; expects i_clk and i_rst_n in the including module.
`ifndef WINDOW_CONVOLUTION_3X3_MACROS_SVH
`define WINDOW_CONVOLUTION_3X3_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define WCV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define WCV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wcv_pkg.sv */
// Shared types and constants of the 3x3 window convolution.
// No dependencies; used by every module of the block except wcv_line_mem.
`default_nettype none

package wcv_pkg;

    localparam int KERNEL_SIZE = 3;
    localparam int PIX_W       = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = 32;
    localparam int ROWSUM_W    = 34;
    localparam int FULLSUM_W   = 36;
    localparam int SUM_W       = 35;
    localparam int POS_W       = 10;
    localparam int DIM_REG_W   = 11;
    localparam int COEF_REG_W  = 48;
    localparam int APB_DW      = 64;
    localparam int APB_AW      = 6;
    localparam int OUT_TDATA_W = 56;
    localparam int LINE_WORD_W = 2 * PIX_W;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 11'd1024;

    // Register indexes on the configuration port (byte address = 8 * index).
    typedef enum logic [2:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_COEF_TOP = 3'd2,
        REG_COEF_MID = 3'd3,
        REG_COEF_BOT = 3'd4
    } t_reg_idx;

    // Nine coefficients, [row][col], row 0 applies to the oldest image row.
    typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][COEF_W-1:0] t_coef_set;

    // Position and frame marker that travel with a result through the pipeline.
    typedef struct packed {
        logic [POS_W-1:0] center_row;
        logic [POS_W-1:0] center_col;
        logic             frame_end;
    } t_meta;

endpackage

`default_nettype wire

/* sv/wcv_line_mem.sv */
// Line store memory: two previous image rows packed in one word per column.
// Simple dual-port synchronous RAM, registered read; no package dependency.
`default_nettype none

module wcv_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* sv/wcv_cfg.sv */
// Configuration registers on an APB-style port, plus clamped image dimensions.
// Depends on wcv_pkg.
`default_nettype none

module wcv_cfg #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int WDIM_W     = 11,
    parameter int HDIM_W     = 11
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [wcv_pkg::APB_AW-1:0]   paddr,
    input  wire logic [wcv_pkg::APB_DW-1:0]   pwdata,
    output logic      [wcv_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output logic      [WDIM_W-1:0]            o_eff_width,
    output logic      [HDIM_W-1:0]            o_eff_height,
    output wcv_pkg::t_coef_set                o_coef
);

    logic [wcv_pkg::DIM_REG_W-1:0]  r_width;
    logic [wcv_pkg::DIM_REG_W-1:0]  r_height;
    logic [wcv_pkg::COEF_REG_W-1:0] r_coef_top;
    logic [wcv_pkg::COEF_REG_W-1:0] r_coef_mid;
    logic [wcv_pkg::COEF_REG_W-1:0] r_coef_bot;
    logic                           w_wr;
    wcv_pkg::t_reg_idx              w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = wcv_pkg::t_reg_idx'(paddr[5:3]);

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= wcv_pkg::DIM_RESET;
            r_height   <= wcv_pkg::DIM_RESET;
            r_coef_top <= '0;
            r_coef_mid <= '0;
            r_coef_bot <= '0;
        end else if (w_wr) begin
            case (w_idx)
                wcv_pkg::REG_WIDTH:    r_width    <= pwdata[wcv_pkg::DIM_REG_W-1:0];
                wcv_pkg::REG_HEIGHT:   r_height   <= pwdata[wcv_pkg::DIM_REG_W-1:0];
                wcv_pkg::REG_COEF_TOP: r_coef_top <= pwdata[wcv_pkg::COEF_REG_W-1:0];
                wcv_pkg::REG_COEF_MID: r_coef_mid <= pwdata[wcv_pkg::COEF_REG_W-1:0];
                wcv_pkg::REG_COEF_BOT: r_coef_bot <= pwdata[wcv_pkg::COEF_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        prdata = '0;
        case (w_idx)
            wcv_pkg::REG_WIDTH:    prdata = wcv_pkg::APB_DW'(r_width);
            wcv_pkg::REG_HEIGHT:   prdata = wcv_pkg::APB_DW'(r_height);
            wcv_pkg::REG_COEF_TOP: prdata = wcv_pkg::APB_DW'(r_coef_top);
            wcv_pkg::REG_COEF_MID: prdata = wcv_pkg::APB_DW'(r_coef_mid);
            wcv_pkg::REG_COEF_BOT: prdata = wcv_pkg::APB_DW'(r_coef_bot);
            default:               prdata = '0;
        endcase
    end

    // Dimensions below the kernel size act as the kernel size, above the maximum as the maximum.
    always_comb begin
        priority if (32'(r_width) < 32'(wcv_pkg::KERNEL_SIZE)) begin
            o_eff_width = WDIM_W'(wcv_pkg::KERNEL_SIZE);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            o_eff_width = WDIM_W'(MAX_WIDTH);
        end else begin
            o_eff_width = WDIM_W'(r_width);
        end
        priority if (32'(r_height) < 32'(wcv_pkg::KERNEL_SIZE)) begin
            o_eff_height = HDIM_W'(wcv_pkg::KERNEL_SIZE);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            o_eff_height = HDIM_W'(MAX_HEIGHT);
        end else begin
            o_eff_height = HDIM_W'(r_height);
        end
    end

    // Unpack coefficients, left coefficient in the low bits of each row register.
    always_comb begin
        for (int j = 0; j < wcv_pkg::KERNEL_SIZE; j++) begin
            o_coef[0][j] = r_coef_top[j*wcv_pkg::COEF_W +: wcv_pkg::COEF_W];
            o_coef[1][j] = r_coef_mid[j*wcv_pkg::COEF_W +: wcv_pkg::COEF_W];
            o_coef[2][j] = r_coef_bot[j*wcv_pkg::COEF_W +: wcv_pkg::COEF_W];
        end
    end

endmodule

`default_nettype wire

/* sv/wcv_window_mac.sv */
// 3x3 window register and multiply-accumulate pipeline (products, row sums).
// Depends on wcv_pkg.
`default_nettype none

module wcv_window_mac (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_adv,
    input  wire logic                              i_shift,
    input  wire logic                              i_produce,
    input  wire logic signed [wcv_pkg::PIX_W-1:0]  i_two_up,
    input  wire logic signed [wcv_pkg::PIX_W-1:0]  i_one_up,
    input  wire logic signed [wcv_pkg::PIX_W-1:0]  i_pixel,
    input  wire wcv_pkg::t_meta                    i_meta,
    input  wire wcv_pkg::t_coef_set                i_coef,
    output logic                                   o_valid,
    output logic signed [wcv_pkg::SUM_W-1:0]       o_sum,
    output wcv_pkg::t_meta                         o_meta
);

    localparam int K = wcv_pkg::KERNEL_SIZE;

    logic signed [wcv_pkg::PIX_W-1:0]    r_win    [K][K];
    logic                                r_b_valid;
    wcv_pkg::t_meta                      r_b_meta;
    logic signed [wcv_pkg::PROD_W-1:0]   r_prod   [K][K];
    logic                                r_c_valid;
    wcv_pkg::t_meta                      r_c_meta;
    logic signed [wcv_pkg::ROWSUM_W-1:0] r_rowsum [K];
    logic                                r_d_valid;
    wcv_pkg::t_meta                      r_d_meta;
    logic signed [wcv_pkg::FULLSUM_W-1:0] w_full;

    // Window: shift left one column, new column from the two line stores and the pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < K; i++) begin
                for (int j = 0; j < K; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_shift) begin
            for (int i = 0; i < K; i++) begin
                for (int j = 0; j < K - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
            end
            r_win[0][K-1] <= i_two_up;
            r_win[1][K-1] <= i_one_up;
            r_win[2][K-1] <= i_pixel;
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_adv) begin
            r_b_valid <= i_shift && i_produce;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    // Products, then row sums, with position carried alongside.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_meta <= i_meta;
            r_c_meta <= r_b_meta;
            r_d_meta <= r_c_meta;
            for (int i = 0; i < K; i++) begin
                for (int j = 0; j < K; j++) begin
                    r_prod[i][j] <= r_win[i][j] * $signed(i_coef[i][j]);
                end
                r_rowsum[i] <= wcv_pkg::ROWSUM_W'(r_prod[i][0])
                             + wcv_pkg::ROWSUM_W'(r_prod[i][1])
                             + wcv_pkg::ROWSUM_W'(r_prod[i][2]);
            end
        end
    end

    // Final add of the three row sums; the result register sits in the top level.
    assign w_full = wcv_pkg::FULLSUM_W'(r_rowsum[0])
                  + wcv_pkg::FULLSUM_W'(r_rowsum[1])
                  + wcv_pkg::FULLSUM_W'(r_rowsum[2]);

    assign o_sum   = w_full[wcv_pkg::SUM_W-1:0];
    assign o_valid = r_d_valid;
    assign o_meta  = r_d_meta;

endmodule

`default_nettype wire

/* sv/window_convolution_3x3.sv */
// 3x3 window convolution over a raster-order pixel stream.
// Slave stream: one signed 16-bit pixel per beat, row by row, left to right.
// Master stream: one beat per interior pixel with the 35-bit signed Q.13 sum,
// the window-center row and column; tlast marks the last result of a frame.
// Border pixels (first two rows, first two columns) produce no beat.
// APB port: width, height and three packed coefficient rows, 8 bytes apart.
// Throughput is one pixel per clock while the receiver does not stall. An accepted
// pixel beat reaches its result beat through the line memory read, window update,
// products, row sums, then the final add into the output register. The rate is set
// by the line memory, read once per pixel and written back from stage A.
// Reset clears the counters, the window and the configuration to its defaults
// (1024 x 1024, zero coefficients); line memory contents are not cleared.
// When the receiver stalls with a result held, the whole pipeline holds and
// s_tready drops; s_tready is high whenever the output register can advance.
// Depends on wcv_pkg, wcv_cfg, wcv_line_mem, wcv_window_mac and the macros header.
`default_nettype none

`include "window_convolution_3x3_macros.svh"

module window_convolution_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Pixel input.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [wcv_pkg::PIX_W-1:0]           s_tdata,   // [15:0] pixel
    // Result output.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [wcv_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [34:0] filtered,
                                                                // [44:35] center_row,
                                                                // [54:45] center_col
    output logic                                     m_tlast,   // frame_end
    // Configuration.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [wcv_pkg::APB_AW-1:0]          paddr,
    input  wire logic [wcv_pkg::APB_DW-1:0]          pwdata,
    output logic      [wcv_pkg::APB_DW-1:0]          prdata,
    output logic                                     pready
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

    logic [WDIM_W-1:0]               w_eff_width;
    logic [HDIM_W-1:0]               w_eff_height;
    wcv_pkg::t_coef_set              w_coef;

    logic                            w_adv;
    logic                            w_accept;
    logic [CW-1:0]                   r_col_cnt;
    logic [RW-1:0]                   r_row_cnt;
    logic [CW-1:0]                   n_col_cnt;
    logic [RW-1:0]                   n_row_cnt;
    logic                            w_produce;
    wcv_pkg::t_meta                  w_meta;

    logic                            r_a_valid;
    logic                            r_a_produce;
    logic [wcv_pkg::PIX_W-1:0]       r_a_pix;
    logic [CW-1:0]                   r_a_col;
    wcv_pkg::t_meta                  r_a_meta;

    logic [wcv_pkg::LINE_WORD_W-1:0] w_rd_word;
    logic                            w_wr_en;
    logic [wcv_pkg::LINE_WORD_W-1:0] w_wr_word;

    logic                            w_mac_valid;
    logic signed [wcv_pkg::SUM_W-1:0] w_mac_sum;
    wcv_pkg::t_meta                  w_mac_meta;

    logic                            r_out_valid;
    logic [wcv_pkg::SUM_W-1:0]       r_out_sum;
    wcv_pkg::t_meta                  r_out_meta;

    // Configuration registers.
    wcv_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WDIM_W     (WDIM_W),
        .HDIM_W     (HDIM_W)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_eff_width  (w_eff_width),
        .o_eff_height (w_eff_height),
        .o_coef       (w_coef)
    );

    // The pipeline moves as a whole whenever the output register is free or being taken.
    assign w_adv    = !r_out_valid || m_tready;
    assign s_tready = w_adv;
    assign w_accept = s_tvalid && w_adv;

    // Interior test and result position for the pixel being accepted.
    always_comb begin
        w_produce = (32'(r_row_cnt) >= 32'd2) && (32'(r_col_cnt) >= 32'd2)
                 && (32'(r_row_cnt) < 32'(w_eff_height))
                 && (32'(r_col_cnt) < 32'(w_eff_width));
        w_meta.center_row = wcv_pkg::POS_W'(32'(r_row_cnt) - 32'd1);
        w_meta.center_col = wcv_pkg::POS_W'(32'(r_col_cnt) - 32'd1);
        w_meta.frame_end  = (32'(r_row_cnt) == 32'(w_eff_height) - 32'd1)
                         && (32'(r_col_cnt) == 32'(w_eff_width) - 32'd1);
    end

    // Raster counters; a column at or past the width wraps at once.
    always_comb begin
        n_col_cnt = r_col_cnt;
        n_row_cnt = r_row_cnt;
        if (32'(r_col_cnt) + 32'd1 >= 32'(w_eff_width)) begin
            n_col_cnt = '0;
            if (32'(r_row_cnt) + 32'd1 >= 32'(w_eff_height)) begin
                n_row_cnt = '0;
            end else begin
                n_row_cnt = RW'(32'(r_row_cnt) + 32'd1);
            end
        end else begin
            n_col_cnt = CW'(32'(r_col_cnt) + 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (w_accept) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    // Stage A: pixel waits here while its column is read from the line memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_pix     <= s_tdata;
            r_a_col     <= r_col_cnt;
            r_a_produce <= w_produce;
            r_a_meta    <= w_meta;
        end
    end

    // Line memory word: [31:16] one row up, [15:0] two rows up.
    // Write-back moves one-up into two-up and stores the new pixel as one-up.
    assign w_wr_en   = w_adv && r_a_valid;
    assign w_wr_word = {r_a_pix, w_rd_word[wcv_pkg::LINE_WORD_W-1:wcv_pkg::PIX_W]};

    wcv_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (wcv_pkg::LINE_WORD_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col_cnt),
        .o_rd_data (w_rd_word),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_a_col),
        .i_wr_data (w_wr_word)
    );

    // Window and multiply-accumulate stages.
    wcv_window_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_shift   (w_wr_en),
        .i_produce (r_a_produce),
        .i_two_up  ($signed(w_rd_word[wcv_pkg::PIX_W-1:0])),
        .i_one_up  ($signed(w_rd_word[wcv_pkg::LINE_WORD_W-1:wcv_pkg::PIX_W])),
        .i_pixel   ($signed(r_a_pix)),
        .i_meta    (r_a_meta),
        .i_coef    (w_coef),
        .o_valid   (w_mac_valid),
        .o_sum     (w_mac_sum),
        .o_meta    (w_mac_meta)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_mac_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_mac_valid) begin
            r_out_sum  <= w_mac_sum;
            r_out_meta <= w_mac_meta;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_out_meta.center_col, r_out_meta.center_row, r_out_sum};
    assign m_tlast  = r_out_meta.frame_end;

    // Consecutive pixels never share a column, so the read and write-back never collide.
    `WCV_ASSERT_NOW(a_no_mem_collision, w_accept && w_wr_en, r_col_cnt != r_a_col,
        "line memory read and write-back hit the same column")

    // The column counter steps by one or wraps to zero on every accepted pixel.
    `WCV_ASSERT_NEXT(a_col_step, w_accept,
        (r_col_cnt == CW'(32'($past(r_col_cnt)) + 32'd1)) || (r_col_cnt == '0),
        "column counter skipped a value")

    // The row counter only changes when the column counter wraps.
    `WCV_ASSERT_NEXT(a_row_on_wrap, w_accept,
        (r_row_cnt == $past(r_row_cnt)) || (r_col_cnt == '0),
        "row counter changed in the middle of a row")

endmodule

`default_nettype wire

/* dv/tb_window_convolution_3x3.sv */
`timescale 1ns / 1ps
// Self-checking testbench for window_convolution_3x3: pixel stream in, filtered stream out.
// Uses wcv_pkg for widths and register indexes and an in-bench predictor of the block.

module tb_window_convolution_3x3;

    import wcv_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int SETTLE_CYCLES = 8;        // pipeline depth plus margin
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PIXELS = 1900;
    localparam int MAX_REPORTS   = 40;

    localparam logic [APB_DW-1:0] DIM_MASK  = {{(APB_DW-DIM_REG_W){1'b0}}, {DIM_REG_W{1'b1}}};
    localparam logic [APB_DW-1:0] COEF_MASK = {{(APB_DW-COEF_REG_W){1'b0}}, {COEF_REG_W{1'b1}}};
    localparam t_reg_idx COEF_REGS [KERNEL_SIZE] = '{REG_COEF_TOP, REG_COEF_MID, REG_COEF_BOT};

    // One filtered pixel as it leaves the block.
    typedef struct packed {
        logic [SUM_W-1:0] filtered;
        logic [POS_W-1:0] center_row;
        logic [POS_W-1:0] center_col;
        logic             frame_end;
    } conv_result_t;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

    // One line of the directed stimulus: a register write or a pixel beat.
    typedef struct packed {
        row_kind_e        kind;
        t_reg_idx         idx;
        logic [APB_DW-1:0] value;
        logic [PIX_W-1:0] pixel;
        logic             has_exp;
        conv_result_t     res;
    } stim_row_t;

    localparam conv_result_t NO_RESULT = '0;
    // Nine products of -32768 by -4.0 (Q2.13), each 2^30, at the only interior pixel.
    localparam conv_result_t FULL_SCALE_SUM = '{filtered: 35'd9663676416, center_row: 10'd1,
                                                center_col: 10'd1, frame_end: 1'b1};

    // DUT connections.
    logic                    i_clk    = 1'b0;
    logic                    i_rst_n  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [PIX_W-1:0]        s_tdata  = '0;   // [15:0] pixel
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;         // [34:0] filtered, [44:35] row, [54:45] col
    logic                    m_tlast;         // frame_end
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_AW-1:0]       paddr    = '0;
    logic [APB_DW-1:0]       pwdata   = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    // Predictor state: configuration, line stores, window and raster position.
    logic [DIM_REG_W-1:0]        cfg_width  = DIM_RESET;
    logic [DIM_REG_W-1:0]        cfg_height = DIM_RESET;
    logic [COEF_REG_W-1:0]       coef_rows [KERNEL_SIZE] = '{default: '0};
    logic signed [PIX_W-1:0]     row_above_px [MAX_W] = '{default: '0};
    logic signed [PIX_W-1:0]     row_two_above_px [MAX_W] = '{default: '0};
    logic signed [PIX_W-1:0]     win_px [KERNEL_SIZE][KERNEL_SIZE] = '{default: '{default: '0}};
    int                          col_pos = 0;
    int                          row_pos = 0;

    conv_result_t expected_q [$];
    conv_result_t typed_res;
    bit           typed_valid = 1'b0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           idle_pct = 38;
    int           pixels_sent = 0;

    stim_row_t dir_table [31] = '{
        '{ROW_CFG, REG_WIDTH,    64'd0,                  16'h0000, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_HEIGHT,   64'd1,                  16'h0000, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_COEF_TOP, 64'h8000_8000_8000,     16'h0000, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_COEF_MID, 64'h8000_8000_8000,     16'h0000, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_COEF_BOT, 64'h8000_8000_8000,     16'h0000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h8000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h8000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h8000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h8000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h8000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h8000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h8000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h8000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h8000, 1'b1, FULL_SCALE_SUM},
        '{ROW_CFG, REG_COEF_TOP, 64'h7FFF_0001_8000,     16'h0000, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_COEF_MID, 64'hFFFF_0000_7FFF,     16'h0000, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_COEF_BOT, 64'h4000_8000_FFFF,     16'h0000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h7FFF, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h8000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'hFFFF, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h0001, 1'b0, NO_RESULT},
        // Frame grows by one row while its second row is in progress.
        '{ROW_CFG, REG_HEIGHT,   64'hFFFF_0000_0000_0004, 16'h0000, 1'b0, NO_RESULT},
        '{ROW_CFG, REG_COEF_MID, 64'h8000_7FFF_2000,     16'h0000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h0000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h5555, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'hAAAA, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h7FFF, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h8000, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h1234, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'hFFFF, 1'b0, NO_RESULT},
        '{ROW_PIX, REG_WIDTH,    64'd0,                  16'h8001, 1'b0, NO_RESULT}
    };

    window_convolution_3x3 #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int eff_dim(input logic [DIM_REG_W-1:0] v, input int lim);
        if (v < KERNEL_SIZE)
            return KERNEL_SIZE;
        if (v > lim)
            return lim;
        return int'(v);
    endfunction

    // Pixels still needed to bring the raster position back to the frame start.
    function automatic int frame_pixels_left();
        int w, h, rest;
        w = eff_dim(cfg_width, MAX_W);
        h = eff_dim(cfg_height, MAX_H);
        rest = (col_pos >= w) ? 1 : w - col_pos;
        if (row_pos + 1 < h)
            rest += (h - row_pos - 1) * w;
        return rest;
    endfunction

    // Advance the line stores and window by one pixel and form the sum when interior.
    task automatic convolve_pixel(input logic [PIX_W-1:0] px, output bit made,
                                  output conv_result_t res);
        int w, h;
        logic signed [PIX_W-1:0] oldest, middle;
        logic signed [COEF_W-1:0] k;
        longint acc;
        w = eff_dim(cfg_width, MAX_W);
        h = eff_dim(cfg_height, MAX_H);
        oldest = '0;
        middle = '0;
        made = 1'b0;
        res = NO_RESULT;
        if (col_pos < MAX_W) begin
            oldest = row_two_above_px[col_pos];
            middle = row_above_px[col_pos];
            row_two_above_px[col_pos] = middle;
            row_above_px[col_pos] = px;
        end
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            win_px[r][0] = win_px[r][1];
            win_px[r][1] = win_px[r][2];
        end
        win_px[0][2] = oldest;
        win_px[1][2] = middle;
        win_px[2][2] = px;

        if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w) begin
            acc = 0;
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                for (int c = 0; c < KERNEL_SIZE; c++) begin
                    k = coef_rows[r][COEF_W*c +: COEF_W];
                    acc += longint'(win_px[r][c]) * longint'(k);
                end
            end
            res.filtered   = acc[SUM_W-1:0];
            res.center_row = POS_W'(row_pos - 1);
            res.center_col = POS_W'(col_pos - 1);
            res.frame_end  = (row_pos == h - 1 && col_pos == w - 1);
            made = 1'b1;
        end

        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    // Beats are sampled at the falling edge, where every signal is settled,
    // and take effect at the following rising edge.
    always @(negedge i_clk) begin : beat_monitor
        conv_result_t got, want, pred;
        bit made;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got.filtered   = m_tdata[SUM_W-1:0];
                got.center_row = m_tdata[SUM_W +: POS_W];
                got.center_col = m_tdata[SUM_W+POS_W +: POS_W];
                got.frame_end  = m_tlast;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat row %0d col %0d",
                                              got.center_row, got.center_col));
                end else begin
                    want = expected_q.pop_front();
                    if (got.filtered !== want.filtered)
                        report_mismatch($sformatf("filtered: expected %0d got %0d",
                                                  $signed(want.filtered), $signed(got.filtered)));
                    if (got.center_row !== want.center_row)
                        report_mismatch($sformatf("center_row: expected %0d got %0d",
                                                  want.center_row, got.center_row));
                    if (got.center_col !== want.center_col)
                        report_mismatch($sformatf("center_col: expected %0d got %0d",
                                                  want.center_col, got.center_col));
                    if (got.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end: expected %0b got %0b",
                                                  want.frame_end, got.frame_end));
                end
            end
            if (s_tvalid && s_tready) begin
                convolve_pixel(s_tdata, made, pred);
                if (typed_valid) begin
                    expected_q.push_back(typed_res);
                    typed_valid = 1'b0;
                end else if (made) begin
                    expected_q.push_back(pred);
                end
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        bit taken;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do begin
            @(negedge i_clk);
            taken = s_tready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Hold the sender until every expected result is out and the pipeline has emptied.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write followed by a read back, always on an idle block.
    task automatic cfg_write(input t_reg_idx idx, input logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] kept, got;
        bit rdy;
        wait_idle();
        kept = (idx == REG_WIDTH || idx == REG_HEIGHT) ? (val & DIM_MASK) : (val & COEF_MASK);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 3'b000});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = pready;
            @(posedge i_clk);
        end while (!rdy);
        case (idx)
            REG_WIDTH:    cfg_width    = kept[DIM_REG_W-1:0];
            REG_HEIGHT:   cfg_height   = kept[DIM_REG_W-1:0];
            REG_COEF_TOP: coef_rows[0] = kept[COEF_REG_W-1:0];
            REG_COEF_MID: coef_rows[1] = kept[COEF_REG_W-1:0];
            REG_COEF_BOT: coef_rows[2] = kept[COEF_REG_W-1:0];
            default: ;
        endcase

        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = pready;
            got = prdata;
            @(posedge i_clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== kept)
            report_mismatch($sformatf("register %s read back %h, expected %h",
                                      idx.name(), got, kept));
    endtask

    // Random bits above the register field; the block must ignore them.
    function automatic logic [APB_DW-1:0] pad_junk(input logic [APB_DW-1:0] field,
                                                   input logic [APB_DW-1:0] keep);
        return ({$urandom, $urandom} & ~keep) | (field & keep);
    endfunction

    function automatic logic [DIM_REG_W-1:0] rand_dim(input int hi);
        if ($urandom_range(19) == 0)
            return DIM_REG_W'($urandom_range(0, KERNEL_SIZE - 1));
        return DIM_REG_W'($urandom_range(KERNEL_SIZE, hi));
    endfunction

    function automatic logic [COEF_REG_W-1:0] rand_coef_row();
        case ($urandom_range(5))
            0: return {KERNEL_SIZE{16'h8000}};
            1: return {KERNEL_SIZE{16'h7FFF}};
            2: return '0;
            default: return COEF_REG_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_random(input int n);
        repeat (n) begin
            send_pixel(rand_pixel());
            pixels_sent++;
        end
    endtask

    // One phase: new frame size and coefficients, then whole frames of random pixels,
    // optionally interrupted once for a mid-frame register change.
    task automatic play_frames(input logic [DIM_REG_W-1:0] w, input logic [DIM_REG_W-1:0] h,
                               input int extra_frames, input bit split_ok);
        int left, cut;
        cfg_write(REG_WIDTH, pad_junk(w, DIM_MASK));
        cfg_write(REG_HEIGHT, pad_junk(h, DIM_MASK));
        foreach (COEF_REGS[k])
            if ($urandom_range(1))
                cfg_write(COEF_REGS[k], pad_junk(rand_coef_row(), COEF_MASK));
        left = frame_pixels_left()
             + extra_frames * eff_dim(cfg_width, MAX_W) * eff_dim(cfg_height, MAX_H);
        if (split_ok && left > 1 && $urandom_range(3) == 0) begin
            cut = $urandom_range(1, left - 1);
            send_random(cut);
            // Height may move either way mid-frame; width may not grow, so that
            // every line-store entry read was written in an earlier row.
            cfg_write(REG_HEIGHT, pad_junk(rand_dim(8), DIM_MASK));
            if ($urandom_range(1))
                cfg_write(REG_WIDTH,
                          pad_junk($urandom_range(0, eff_dim(cfg_width, MAX_W)), DIM_MASK));
            cfg_write(REG_COEF_MID, pad_junk(rand_coef_row(), COEF_MASK));
            left = frame_pixels_left();
        end
        send_random(left);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes, clamped sizes and a mid-frame height change.
        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG) begin
                cfg_write(dir_table[i].idx, dir_table[i].value);
            end else begin
                typed_res   = dir_table[i].res;
                typed_valid = dir_table[i].has_exp;
                send_pixel(dir_table[i].pixel);
            end
        end

        // Random part on small frames; one long stretch runs without any idling.
        while (pixels_sent < RANDOM_PIXELS) begin
            idle_pct = (pixels_sent >= 600 && pixels_sent < 1000) ? 0 : 38;
            play_frames(rand_dim(14), rand_dim(8), $urandom_range(0, 1), 1'b1);
        end

        // Largest sizes: a maximal row (register above the limit) and maximal column.
        idle_pct = 38;
        play_frames(11'd2047, 11'd3, 0, 1'b0);
        play_frames(11'd3, 11'd1024, 0, 1'b0);

        wait_idle();
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
